### rtl/ffpu_pkg.sv
// ----------------------------------------------------------------------------
// ffpu_pkg: shared types and constants of the float format pack/unpack unit
// Stage payload structs, register indexes and field widths.
// ----------------------------------------------------------------------------
package ffpu_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned FracW  = 52;
  localparam int unsigned SigW   = 53;
  localparam int unsigned ExpW   = 13;
  localparam int unsigned TbW    = 7;
  localparam int unsigned EbW    = 4;
  localparam int unsigned SW     = 6;
  localparam int unsigned BexpW  = 11;

  typedef enum logic {
    CMD_PACK   = 1'b0,
    CMD_UNPACK = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_TOTAL_BITS = 1'b0,
    REG_EXP_BITS   = 1'b1
  } reg_idx_t;

  // Output of the decode stage.
  typedef struct packed {
    logic                    valid;
    cmd_t                    cmd;
    logic                    bad;
    logic                    sgn;
    logic                    zero;
    logic                    special;
    logic [FracW-1:0]        frac;
    logic signed [ExpW-1:0]  ex;
    logic [DataW-1:0]        w;
    logic [SW-1:0]           s;
    logic [TbW-1:0]          tb;
    logic [BexpW-1:0]        emask;
    logic [BexpW-1:0]        bias;
  } dec_t;

  // Output of the significand stage.
  typedef struct packed {
    logic                    valid;
    cmd_t                    cmd;
    logic                    bad;
    logic                    sgn;
    logic                    zero;
    logic                    special;
    logic [SigW-1:0]         sig;
    logic [BexpW-1:0]        efield;
    logic                    perr;
    logic signed [ExpW-1:0]  ushift;
    logic [SW-1:0]           s;
    logic [TbW-1:0]          tb;
    logic [BexpW-1:0]        emask;
  } sig_t;

endpackage

### rtl/ffpu_decode.sv
// ----------------------------------------------------------------------------
// ffpu_decode: first pipeline stage
// Checks the width setting, splits the binary64 input, normalizes subnormals
// and masks the custom word for unpack.
// ----------------------------------------------------------------------------
module ffpu_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  ffpu_pkg::cmd_t                cmd,
  input  logic [ffpu_pkg::DataW-1:0]    value,
  input  logic [ffpu_pkg::TbW-1:0]      total_bits,
  input  logic [ffpu_pkg::EbW-1:0]      exp_bits,
  output ffpu_pkg::dec_t                dec_r
);

  ffpu_pkg::dec_t                       dec_nxt;
  logic [7:0]                           sfull;
  logic [ffpu_pkg::BexpW-1:0]           bexp;
  logic [ffpu_pkg::FracW-1:0]           frac;
  logic [5:0]                           p;
  logic signed [ffpu_pkg::ExpW-1:0]     shift;
  logic [ffpu_pkg::DataW-1:0]           tmask;

  always_comb begin
    sfull = {1'b0, total_bits} - {4'b0, exp_bits} - 8'd1;
    bexp  = value[62:52];
    frac  = value[ffpu_pkg::FracW-1:0];
    // Highest set bit of the fraction, used only for subnormals.
    p = 6'd0;
    for (int i = 0; i < ffpu_pkg::FracW; i++) begin
      if (frac[i]) p = 6'(i);
    end
    dec_nxt.valid   = in_valid;
    dec_nxt.cmd     = cmd;
    dec_nxt.bad     = (exp_bits < 4'd1) || (exp_bits > 4'd11) || (total_bits > 7'd64) ||
                      ({1'b0, total_bits} < ({4'b0, exp_bits} + 8'd2)) || (sfull > 8'd52);
    dec_nxt.sgn     = value[63];
    dec_nxt.zero    = (bexp == 11'd0) && (frac == '0);
    dec_nxt.special = (bexp == 11'h7FF);
    dec_nxt.s       = sfull[ffpu_pkg::SW-1:0];
    dec_nxt.tb      = total_bits;
    dec_nxt.bias    = (11'd1 << (exp_bits - 4'd1)) - 11'd1;
    dec_nxt.emask   = 11'((12'd1 << exp_bits) - 12'd1);
    if (bexp == 11'd0) begin
      shift        = $signed({7'd0, p}) - 13'sd1074;
      dec_nxt.frac = frac << (6'd52 - p);
    end else begin
      shift        = $signed({2'b00, bexp}) - 13'sd1023;
      dec_nxt.frac = frac;
    end
    dec_nxt.ex = shift + $signed({2'b00, dec_nxt.bias});
    tmask      = (total_bits >= 7'd64) ? '1 : ((64'd1 << total_bits) - 64'd1);
    dec_nxt.w  = value & tmask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

### rtl/ffpu_signif.sv
// ----------------------------------------------------------------------------
// ffpu_signif: second pipeline stage
// Rounds the fraction into the custom significand and wraps the exponent for
// pack; extracts sign, mantissa and unbiased exponent for unpack.
// ----------------------------------------------------------------------------
module ffpu_signif (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  ffpu_pkg::dec_t   dec_r,
  output ffpu_pkg::sig_t   sig_r
);

  ffpu_pkg::sig_t       sig_nxt;
  logic [5:0]           low;
  logic [53:0]          hi;
  logic [53:0]          rem;
  logic [53:0]          r;
  logic [53:0]          rsum;
  logic [63:0]          wsh;
  logic [63:0]          mant;
  logic [5:0]           tbm1;

  always_comb begin
    low  = 6'd52 - dec_r.s;
    hi   = {2'b00, dec_r.frac} >> low;
    rem  = {2'b00, dec_r.frac} & ((54'd1 << low) - 54'd1);
    r    = rem << (7'(dec_r.s) + 7'd1);
    rsum = r + {2'b00, dec_r.frac};
    wsh  = dec_r.w >> dec_r.s;
    mant = dec_r.w & ((64'd1 << dec_r.s) - 64'd1);
    tbm1 = 6'(dec_r.tb - 7'd1);

    sig_nxt.valid   = dec_r.valid;
    sig_nxt.cmd     = dec_r.cmd;
    sig_nxt.bad     = dec_r.bad;
    sig_nxt.special = dec_r.special;
    sig_nxt.s       = dec_r.s;
    sig_nxt.tb      = dec_r.tb;
    sig_nxt.emask   = dec_r.emask;
    sig_nxt.efield  = dec_r.ex[10:0] & dec_r.emask;
    sig_nxt.perr    = (dec_r.ex < 13'sd0) || ({1'b0, dec_r.ex[11:0]} > {2'b00, dec_r.emask});
    sig_nxt.ushift  = $signed({2'b00, wsh[10:0] & dec_r.emask}) -
                      $signed({2'b00, dec_r.bias});
    if (dec_r.cmd == ffpu_pkg::CMD_PACK) begin
      sig_nxt.sgn  = dec_r.sgn;
      sig_nxt.zero = dec_r.zero;
      sig_nxt.sig  = 53'(hi + {53'd0, rsum[53]});
    end else begin
      sig_nxt.sgn  = dec_r.w[tbm1];
      sig_nxt.zero = (dec_r.w == '0);
      sig_nxt.sig  = mant[52:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r.valid <= 1'b0;
    end else if (en) begin
      sig_r <= sig_nxt;
    end
  end

endmodule

### rtl/ffpu_assemble.sv
// ----------------------------------------------------------------------------
// ffpu_assemble: third pipeline stage and output register
// Places the fields into the custom word or the binary64 pattern and applies
// the saturation and error rules.
// ----------------------------------------------------------------------------
module ffpu_assemble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  ffpu_pkg::sig_t                sig_r,
  output logic                          out_valid_r,
  output logic [ffpu_pkg::DataW-1:0]    result_r,
  output logic                          err_r
);

  logic [ffpu_pkg::DataW-1:0] result_nxt;
  logic                       err_nxt;
  logic [63:0]                sgn_c;
  logic [63:0]                ef_c;
  logic [63:0]                em_c;
  logic [10:0]                uexp;

  always_comb begin
    sgn_c = {63'd0, sig_r.sgn} << (sig_r.tb - 7'd1);
    ef_c  = {53'd0, sig_r.efield} << sig_r.s;
    em_c  = {53'd0, sig_r.emask} << sig_r.s;
    uexp  = 11'(sig_r.ushift + 13'sd1023);
    result_nxt = '0;
    err_nxt    = 1'b0;
    if (sig_r.bad) begin
      err_nxt = 1'b1;
    end else if (sig_r.cmd == ffpu_pkg::CMD_PACK) begin
      if (sig_r.zero) begin
        result_nxt = '0;
      end else if (sig_r.special) begin
        result_nxt = sgn_c | em_c;
        err_nxt    = 1'b1;
      end else begin
        result_nxt = sgn_c | ef_c | {11'd0, sig_r.sig};
        err_nxt    = sig_r.perr;
      end
    end else begin
      if (sig_r.zero) begin
        result_nxt = '0;
      end else if (sig_r.ushift > 13'sd1023) begin
        result_nxt = {sig_r.sgn, 11'h7FF, 52'd0};
        err_nxt    = 1'b1;
      end else if (sig_r.ushift < -13'sd1022) begin
        result_nxt = {sig_r.sgn, 63'd0};
        err_nxt    = 1'b1;
      end else begin
        result_nxt = {sig_r.sgn, uexp, 52'd0} |
                     ({11'd0, sig_r.sig} << (6'd52 - sig_r.s));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sig_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

### rtl/float_format_pack_unpack_unit.sv
// ----------------------------------------------------------------------------
// float_format_pack_unpack_unit: binary64 <-> custom float converter
// Three-stage pipeline that packs binary64 into a configurable float layout
// or unpacks such a word back to binary64.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock while the output side is not
// stalled and returns exactly one result transaction for each, in order. A
// transaction accepted at the input passes three register stages before it
// is presented on the output. The three stages are decode (width check,
// subnormal normalization through a leading-one search), significand
// rounding, and final assembly into the output register. The whole pipeline
// advances together: when a result sits in the output register and the
// output side does not take it, every stage holds and in_tready drops, so no
// transaction is lost or repeated. The custom word holds sign, exponent and
// significand with s = total_bits - exp_bits - 1 significand bits and bias
// 2^(exp_bits-1) - 1; it has no infinities, NaNs or subnormals. A width
// setting that is out of range yields a result of zero with range_error set.
// Configuration must only be written while no transaction is in flight.
module float_format_pack_unpack_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port: index 0 is total_bits, index 1 is exp_bits.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  input  logic        in_tuser,   // [0] command (0 pack, 1 unpack)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] result
  output logic        out_tuser   // [0] range_error
);

  logic [ffpu_pkg::TbW-1:0] total_bits_r;
  logic [ffpu_pkg::EbW-1:0] exp_bits_r;
  logic                     en;
  ffpu_pkg::dec_t           dec_r;
  ffpu_pkg::sig_t           sig_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_bits_r <= 7'd32;
      exp_bits_r   <= 4'd8;
    end else if (cfg_we) begin
      unique case (ffpu_pkg::reg_idx_t'(cfg_addr))
        ffpu_pkg::REG_TOTAL_BITS: total_bits_r <= cfg_wdata;
        ffpu_pkg::REG_EXP_BITS:   exp_bits_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being drained.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  ffpu_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .cmd        (ffpu_pkg::cmd_t'(in_tuser)),
    .value      (in_tdata),
    .total_bits (total_bits_r),
    .exp_bits   (exp_bits_r),
    .dec_r      (dec_r)
  );

  ffpu_signif u_signif (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .dec_r (dec_r),
    .sig_r (sig_r)
  );

  ffpu_assemble u_assemble (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .sig_r       (sig_r),
    .out_valid_r (out_tvalid),
    .result_r    (out_tdata),
    .err_r       (out_tuser)
  );

endmodule

### rtl/ffpu_checker.sv
// ----------------------------------------------------------------------------
// ffpu_checker: port-level checks for the pack/unpack unit
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module ffpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  // No result may appear right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The input side is open exactly when the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output stall");

  // With nothing accepted while the stages empty out, no result is pending.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) && out_tready ##1 !(in_tvalid && in_tready) && out_tready
    ##1 !(in_tvalid && in_tready) && out_tready |=> !out_tvalid)
    else $error("result without accepted transaction");

endmodule

bind float_format_pack_unpack_unit ffpu_checker u_ffpu_checker (.*);

### tb/sv/ffpu_checker.sv
// ----------------------------------------------------------------------------
// ffpu_result_checker: result checker of the float format pack/unpack unit
// Watches the configuration port and both stream channels, predicts each
// result from the accepted command and compares it with the unit's output.
// ----------------------------------------------------------------------------
module ffpu_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] word;
    logic        range_err;
  } conv_result_t;

  logic [6:0]   total_bits;
  logic [3:0]   exp_bits;
  conv_result_t awaited_q[$];

  // Converts one value under the given widths.
  function automatic conv_result_t convert(ffpu_pkg::cmd_t cmd, logic [63:0] v,
                                           logic [6:0] tb, logic [3:0] eb);
    conv_result_t r;
    int           s, bias, shift, ex, p, low;
    logic         sgn;
    logic [10:0]  bexp;
    logic [63:0]  frac, emask, hi, rem, sig, efield, w, mant;
    r.word = '0;
    r.range_err = 1'b0;
    if (eb < 1 || eb > 11 || tb > 64 || tb < eb + 2 || tb - eb - 1 > 52) begin
      r.range_err = 1'b1;
      return r;
    end
    s     = tb - eb - 1;
    emask = (64'd1 << eb) - 1;
    bias  = (1 << (eb - 1)) - 1;
    if (cmd == ffpu_pkg::CMD_PACK) begin
      sgn  = v[63];
      bexp = v[62:52];
      frac = {12'd0, v[51:0]};
      if (bexp == 0 && frac == 0) return r;
      if (bexp == 11'h7FF) begin
        r.range_err = 1'b1;
        r.word = (64'(sgn) << (tb - 1)) | (emask << s);
        return r;
      end
      if (bexp == 0) begin
        // Subnormal input: move the leading one up to the hidden bit.
        p = 51;
        while (p > 0 && !frac[p]) p--;
        shift = p - 1074;
        frac  = (frac << (52 - p)) & ((64'd1 << 52) - 1);
      end else begin
        shift = int'(bexp) - 1023;
      end
      low = 52 - s;
      hi  = frac >> low;
      rem = (frac & ((64'd1 << low) - 1)) << (s + 1);
      sig = hi + ((rem + frac) >> 53);
      ex  = shift + bias;
      if (ex < 0 || 64'(ex) > emask) r.range_err = 1'b1;
      efield = 64'(ex) & emask;
      r.word = (64'(sgn) << (tb - 1)) | (efield << s) | sig;
    end else begin
      w = v;
      if (tb < 64) w &= (64'd1 << tb) - 1;
      if (w == 0) return r;
      sgn    = w[tb - 1];
      mant   = w & ((64'd1 << s) - 1);
      efield = (w >> s) & emask;
      shift  = int'(efield) - bias;
      if (shift > 1023) begin
        r.range_err = 1'b1;
        r.word = {sgn, 11'h7FF, 52'd0};
      end else if (shift < -1022) begin
        r.range_err = 1'b1;
        r.word = {sgn, 63'd0};
      end else begin
        r.word = {sgn, 11'(shift + 1023), 52'd0} | (mant << (52 - s));
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ffpu_result_checker: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;
  assign pending = awaited_q.size();

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst_n) begin
      total_bits <= 7'd32;
      exp_bits   <= 4'd8;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == ffpu_pkg::REG_TOTAL_BITS) total_bits <= cfg_wdata;
        else exp_bits <= cfg_wdata[3:0];
      end
      if (in_tvalid && in_tready)
        awaited_q = {awaited_q,
                     convert(ffpu_pkg::cmd_t'(in_tuser), in_tdata, total_bits, exp_bits)};
      if (out_tvalid && out_tready) begin
        if (awaited_q.size() == 0) begin
          report("unexpected result", out_tdata, 64'd0);
        end else begin
          want = awaited_q.pop_front();
          if (out_tdata !== want.word) report("result", out_tdata, want.word);
          if (out_tuser !== want.range_err)
            report("range_error", 64'(out_tuser), 64'(want.range_err));
        end
      end
    end
  end

endmodule

### tb/sv/tb_float_format_pack_unpack_unit.sv
// ----------------------------------------------------------------------------
// tb_float_format_pack_unpack_unit: testbench of the float format unit
// Drives directed and random pack/unpack transactions through a series of
// width settings with random stalls on both sides; a checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_float_format_pack_unpack_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [6:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  int          mismatches;
  int          pending;

  // When set, neither side inserts idle cycles.
  bit          calm;
  logic [6:0]  cur_tb;
  logic [3:0]  cur_eb;

  // Width settings visited in order. The first is the reset setting; the
  // list includes the widest and narrowest legal layouts, s = 1 and s = 52,
  // and several illegal ones (zero or oversize exponent, s of zero or above
  // 52, total width above 64).
  localparam int NPHASE = 14;
  localparam logic [6:0] PH_TB[NPHASE] =
    '{7'd32, 7'd64, 7'd3, 7'd13, 7'd54, 7'd16, 7'd12, 7'd127, 7'd24,
      7'd40, 7'd10, 7'd65, 7'd20, 7'd64};
  localparam logic [3:0] PH_EB[NPHASE] =
    '{4'd8, 4'd11, 4'd1, 4'd11, 4'd1, 4'd5, 4'd11, 4'd4, 4'd0,
      4'd11, 4'd3, 4'd15, 4'd6, 4'd11};

  float_format_pack_unpack_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  ffpu_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit of 5 ms, far above the slowest run.
  initial begin
    #5ms;
    $display("tb_float_format_pack_unpack_unit: done, errors");
    $finish;
  end

  // The result side stalls in random bursts unless the run is calm.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && rst_n && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one transaction and holds it until the unit accepts it. The
  // ready is looked at on the falling edge, where it is settled, and the
  // transaction is taken at the following rising edge.
  task automatic send(ffpu_pkg::cmd_t cmd, logic [63:0] v);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= v;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // Drops valid and waits until every predicted result has come back, then
  // lets the pipeline idle before the task returns.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // Writes one register; the write enable is low again before the
  // task returns.
  task automatic write_reg(ffpu_pkg::reg_idx_t idx, logic [6:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Builds a random value. Pack values often get an exponent inside or just
  // beyond the custom range; unpack words often get an extreme exponent field.
  function automatic logic [63:0] rand_value(ffpu_pkg::cmd_t cmd);
    logic [63:0] v;
    int          s, bias, e, pick;
    v    = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    s    = int'(cur_tb) - int'(cur_eb) - 1;
    if (cur_eb < 1 || cur_eb > 11 || s < 1 || s > 52) return v;
    bias = (1 << (cur_eb - 1)) - 1;
    if (cmd == ffpu_pkg::CMD_PACK) begin
      case (pick) inside
        0: v[62:0] = 63'd0;
        1: v[62:52] = 11'h7FF;
        2: v[62:52] = 11'd0;
        [3:6]: begin
          e = 1023 + $urandom_range(0, 2 * bias + 8) - bias - 3;
          if (e < 1) e = 1;
          if (e > 2046) e = 2046;
          v[62:52] = 11'(e);
        end
        default: ;
      endcase
    end else if (pick < 4) begin
      v &= ~(((64'd1 << cur_eb) - 1) << s);
      if (pick[0]) v |= ((64'd1 << cur_eb) - 1) << s;
      if (pick == 3) v &= (64'd1 << (cur_tb - 1)) | (((64'd1 << cur_eb) - 1) << s);
    end
    return v;
  endfunction

  initial begin
    ffpu_pkg::cmd_t cmd;
    calm      = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = ffpu_pkg::REG_TOTAL_BITS;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ffpu_pkg::CMD_PACK;
    cur_tb    = 7'd32;
    cur_eb    = 4'd8;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transactions under the reset layout (8 exponent bits,
    // 23 significand bits): signed zeros, infinities, NaN, smallest and
    // largest subnormals, ordinary and extreme normals, a fraction that
    // carries into the exponent, exponents beyond either end, and unpack
    // words with stray high bits, sign only and the largest field values.
    send(ffpu_pkg::CMD_PACK,   64'h0000_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'h8000_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'h7FF0_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'hFFF0_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'h7FF8_0000_0000_0001);
    send(ffpu_pkg::CMD_PACK,   64'h0000_0000_0000_0001);
    send(ffpu_pkg::CMD_PACK,   64'h800F_FFFF_FFFF_FFFF);
    send(ffpu_pkg::CMD_PACK,   64'h3FF0_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'hC000_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'h7FEF_FFFF_FFFF_FFFF);
    send(ffpu_pkg::CMD_PACK,   64'h0010_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'h3FFF_FFFF_FFFF_FFFF);
    send(ffpu_pkg::CMD_PACK,   64'h4700_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'h3000_0000_0000_0000);
    send(ffpu_pkg::CMD_PACK,   64'h3810_0000_0000_0000);
    send(ffpu_pkg::CMD_UNPACK, 64'h0000_0000_0000_0000);
    send(ffpu_pkg::CMD_UNPACK, 64'hFFFF_FFFF_FFFF_FFFF);
    send(ffpu_pkg::CMD_UNPACK, 64'h0000_0000_3F80_0000);
    send(ffpu_pkg::CMD_UNPACK, 64'hFFFF_FFFF_0000_0000);
    send(ffpu_pkg::CMD_UNPACK, 64'h0000_0000_8000_0000);
    send(ffpu_pkg::CMD_UNPACK, 64'h1234_5678_7F7F_FFFF);
    send(ffpu_pkg::CMD_UNPACK, 64'h0000_0000_0000_0001);

    // Hold off until everything is back before the random part starts.
    drain();

    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph > 0) begin
        drain();
        cur_tb = PH_TB[ph];
        cur_eb = PH_EB[ph];
        write_reg(ffpu_pkg::REG_TOTAL_BITS, PH_TB[ph]);
        write_reg(ffpu_pkg::REG_EXP_BITS, 7'(PH_EB[ph]));
      end
      // The final layout runs without any idling on either side.
      calm = (ph == NPHASE - 1);
      for (int n = 0; n < 86; n++) begin
        cmd = ffpu_pkg::cmd_t'($urandom_range(0, 1));
        send(cmd, rand_value(cmd));
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("tb_float_format_pack_unpack_unit: done, clean");
    end else begin
      $display("tb_float_format_pack_unpack_unit: done, errors");
    end
    $finish;
  end

endmodule
